[design/tsg_pkg.sv]
// Package for the thick segment grid binning block: types, constants, codes.
// Depends on nothing; every other design file imports it.
package tsg_pkg;

    localparam int GRID_SIDE  = 64;
    localparam int FRAC_BITS  = 16;
    localparam int SHIFT      = FRAC_BITS + 1;      // positions kept in half units
    localparam int SLOPE_BITS = 24;
    localparam int EDGE_SH    = SLOPE_BITS - SHIFT; // column edge product scale
    localparam int POS_W      = 40;                 // grid-space position width
    localparam int SLOPE_W    = SLOPE_BITS + 2;
    localparam int CELL_W     = 6;
    localparam int GSZ_W      = 7;
    localparam int MD_W       = 64;                 // shared unit accumulator
    localparam int MD_N       = 35;                 // shared unit operand width
    localparam int DIV_STEPS  = SLOPE_BITS + 1;
    localparam int MUL_STEPS  = MD_N;
    localparam int CNT_W      = 6;
    localparam int ADDR_W     = 5;

    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_ZERO  = 2'd1;
    localparam logic [1:0] FLT_BELOW = 2'd2;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_REACH    = 3'd2;
    localparam logic [2:0] REG_COLUMNS  = 3'd3;
    localparam logic [2:0] REG_ROWS     = 3'd4;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
    } tsg_in_t;

    typedef struct packed {
        logic [CELL_W-1:0] major_cell;
        logic [CELL_W-1:0] minor_first;
        logic [CELL_W-1:0] minor_final;
        logic              axes_swapped;
        logic [1:0]        fault;
        logic              empty_res;
        logic              last;
    } tsg_out_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [23:0]        reach_radius;
        logic [GSZ_W-1:0]   grid_columns;
        logic [GSZ_W-1:0]   grid_rows;
    } tsg_cfg_t;

    typedef enum logic {MD_DIV, MD_MUL} tsg_md_op_t;

    typedef struct packed {
        logic            start;
        tsg_md_op_t      op;
        logic [MD_N-1:0] opnd_a;
        logic [MD_N-1:0] opnd_b;
    } tsg_md_req_t;

    typedef struct packed {
        logic            done;
        logic [MD_W-1:0] result;
    } tsg_md_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_CHECK, ST_DIV, ST_MUL, ST_EDGE, ST_COL, ST_FLUSH
    } tsg_state_t;

endpackage

[design/tsg_cfg.sv]
// APB register file for the grid binning block (origin, reach, grid size).
// Depends on tsg_pkg.
module tsg_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output tsg_pkg::tsg_cfg_t          cfg
);
    import tsg_pkg::*;

    tsg_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = paddr[ADDR_W-1:2];
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.reach_radius <= 24'd65536;
            cfg_reg.grid_columns <= GSZ_W'(GRID_SIDE);
            cfg_reg.grid_rows    <= GSZ_W'(GRID_SIDE);
        end else if (wr_en) begin
            case (idx)
                REG_ORIGIN_X: cfg_reg.origin_x     <= pwdata;
                REG_ORIGIN_Y: cfg_reg.origin_y     <= pwdata;
                REG_REACH:    cfg_reg.reach_radius <= pwdata[23:0];
                REG_COLUMNS:  cfg_reg.grid_columns <= pwdata[GSZ_W-1:0];
                REG_ROWS:     cfg_reg.grid_rows    <= pwdata[GSZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ORIGIN_X: prdata = cfg_reg.origin_x;
            REG_ORIGIN_Y: prdata = cfg_reg.origin_y;
            REG_REACH:    prdata = {8'd0, cfg_reg.reach_radius};
            REG_COLUMNS:  prdata = {25'd0, cfg_reg.grid_columns};
            REG_ROWS:     prdata = {25'd0, cfg_reg.grid_rows};
            default:      prdata = '0;
        endcase
    end

endmodule

[design/tsg_mdu.sv]
// Shared iterative unit: restoring divide (one quotient bit per cycle) and
// shift-add multiply (one multiplier bit per cycle) on one adder. Depends on tsg_pkg.
module tsg_mdu (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tsg_pkg::tsg_md_req_t req,
    output tsg_pkg::tsg_md_rsp_t rsp
);
    import tsg_pkg::*;

    logic             busy_reg, done_reg;
    tsg_md_op_t       op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MD_W-1:0]  a_reg, b_reg;
    logic [MD_N-1:0]  c_reg;
    logic [MD_W-1:0]  addend, sum;
    logic             take;

    // divide: a - b; multiply: a + (bit ? b : 0)
    assign addend = (op_reg == MD_DIV) ? ~b_reg : (c_reg[0] ? b_reg : '0);
    assign sum    = a_reg + addend + {{(MD_W-1){1'b0}}, (op_reg == MD_DIV)};
    assign take   = ~sum[MD_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (req.start)
                busy_reg <= 1'b1;
            else if (busy_reg && (cnt_reg == '0))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            op_reg <= req.op;
            if (req.op == MD_DIV) begin
                a_reg   <= {{(MD_W-MD_N){1'b0}}, req.opnd_a};
                b_reg   <= {{(MD_W-MD_N){1'b0}}, req.opnd_b};
                c_reg   <= '0;
                cnt_reg <= CNT_W'(DIV_STEPS - 1);
            end else begin
                a_reg   <= '0;
                b_reg   <= {{(MD_W-MD_N){1'b0}}, req.opnd_a};
                c_reg   <= req.opnd_b;
                cnt_reg <= CNT_W'(MUL_STEPS - 1);
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (op_reg == MD_DIV) begin
                a_reg <= (take ? sum : a_reg) << 1;
                c_reg <= {c_reg[MD_N-2:0], take};
            end else begin
                a_reg <= sum;
                b_reg <= b_reg << 1;
                c_reg <= c_reg >> 1;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == MD_DIV)
                        ? {{(MD_W-DIV_STEPS){1'b0}}, c_reg[DIV_STEPS-1:0]}
                        : a_reg;

endmodule

[design/thick_segment_grid_binning.sv]
// Top level of the thick segment grid binning block: sequencer, column walker,
// output stage. Depends on tsg_pkg, tsg_cfg, tsg_mdu.
//
// Usage:
//   s_* channel takes one segment request (start point, direction, Q15.16).
//   m_* channel returns one span per touched major-axis column, in column
//   order; the final result of a segment carries last. A segment with no
//   touched cell returns one result with empty_res set (fault 1 for a zero
//   length, fault 2 when its forward end lies below the grid).
//   APB port writes origin, reach and grid size; write only while idle.
// Timing:
//   Setup (prepare, check), then the slope divide and the intercept multiply
//   (both on the one shared shift/add unit), an edge step, then one column
//   walked per cycle (up to 64) unless the output register holds it back, and
//   a flush to close the run. Special cases go straight from setup to flush.
//   s_ready is high only while the sequencer is idle.
// Stall:
//   Results go through a one-entry output register; a held-back m_ready
//   stops the column walk until the register frees up. A new request may be
//   taken while the final result still waits in the output register.
// Reset: synchronous, active low; control and config registers return to their defaults.
module thick_segment_grid_binning (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  tsg_pkg::tsg_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tsg_pkg::tsg_out_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tsg_pkg::*;

    tsg_cfg_t    cfg;
    tsg_md_req_t md_req;
    tsg_md_rsp_t md_rsp;

    tsg_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .cfg(cfg)
    );

    tsg_mdu u_mdu (.aclk(aclk), .aresetn(aresetn), .req(md_req), .rsp(md_rsp));

    assign pready = 1'b1;

    tsg_state_t state_reg, state_next;

    // segment registers (grid space, half units)
    logic signed [POS_W-1:0]   px_reg, py_reg, dx_reg, dy_reg;
    logic signed [POS_W-1:0]   rx_reg, ry_reg, vx_reg, vy_reg, reach_reg;
    logic                      sw_reg;
    logic signed [7:0]         maj_last_reg, min_last_reg;
    logic [1:0]                fault_reg;
    logic [CELL_W-1:0]         cx_reg, lastc_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic                      prod_neg_reg;
    logic signed [POS_W-1:0]   y0_reg, e_reg, yedge_reg;
    tsg_out_t                  pend_reg;
    logic                      pend_valid_reg;
    logic                      out_valid_reg;
    tsg_out_t                  out_reg;

    logic     accept, out_free, push;
    tsg_out_t push_data;

    assign accept   = s_valid & s_ready;
    assign out_free = ~out_valid_reg | m_ready;

    // ---- prepare: swap axes, run forward
    logic signed [POS_W-1:0] ax, ay, mj_r, mn_r, mj_v, mn_v;
    logic                    zero_len, swap;
    logic [GSZ_W-1:0]        cols_sat, rows_sat;

    assign zero_len = (dx_reg == '0) && (dy_reg == '0);
    assign ax       = dx_reg[POS_W-1] ? -dx_reg : dx_reg;
    assign ay       = dy_reg[POS_W-1] ? -dy_reg : dy_reg;
    assign swap     = ay > ax;
    assign mj_r     = swap ? py_reg : px_reg;
    assign mn_r     = swap ? px_reg : py_reg;
    assign mj_v     = swap ? dy_reg : dx_reg;
    assign mn_v     = swap ? dx_reg : dy_reg;
    assign cols_sat = (cfg.grid_columns > GSZ_W'(GRID_SIDE)) ? GSZ_W'(GRID_SIDE)
                                                             : cfg.grid_columns;
    assign rows_sat = (cfg.grid_rows > GSZ_W'(GRID_SIDE)) ? GSZ_W'(GRID_SIDE)
                                                          : cfg.grid_rows;

    // ---- check: forward end, column range
    logic signed [POS_W-1:0] endv, xs, cx_full, xend, lastc, maj_last_w;
    logic                    end_below, has_cols;

    assign endv       = rx_reg + vx_reg + reach_reg;
    assign end_below  = endv[POS_W-1];
    assign xs         = rx_reg - reach_reg;
    assign cx_full    = (xs > 0) ? (xs >>> SHIFT) : '0;
    assign xend       = endv >>> SHIFT;
    assign maj_last_w = POS_W'(maj_last_reg);
    assign lastc      = (xend < maj_last_w) ? xend : maj_last_w;
    assign has_cols   = cx_full <= lastc;

    // ---- divide / multiply hand-offs
    logic signed [POS_W-1:0]   vy_abs, rx_abs;
    logic [DIV_STEPS-1:0]      quot;
    logic signed [SLOPE_W-1:0] slope_new;
    logic signed [MD_W-1:0]    prod, prod_sh;
    logic signed [32:0]        e_init;

    assign vy_abs    = vy_reg[POS_W-1] ? -vy_reg : vy_reg;
    assign rx_abs    = rx_reg[POS_W-1] ? -rx_reg : rx_reg;
    assign quot      = md_rsp.result[DIV_STEPS-1:0];
    assign slope_new = vy_reg[POS_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign prod      = prod_neg_reg ? -$signed(md_rsp.result) : $signed(md_rsp.result);
    assign prod_sh   = prod >>> SLOPE_BITS;
    assign e_init    = slope_reg * $signed({1'b0, cx_reg});

    // ---- column step: minor span between this edge and the next
    logic signed [POS_W-1:0] e_n, y_n, y_lo, y_hi, first_w, fin_raw, fin_w, min_last_w;
    logic                    col_emit, col_go, col_end;
    tsg_out_t                col_res;

    assign e_n        = e_reg + POS_W'(slope_reg);
    assign y_n        = (e_n >>> EDGE_SH) + y0_reg;
    assign y_lo       = ((yedge_reg < y_n) ? yedge_reg : y_n) - reach_reg;
    assign y_hi       = ((yedge_reg < y_n) ? y_n : yedge_reg) + reach_reg;
    assign first_w    = (y_lo > 0) ? (y_lo >>> SHIFT) : '0;
    assign fin_raw    = y_hi >>> SHIFT;
    assign min_last_w = POS_W'(min_last_reg);
    assign fin_w      = (fin_raw > min_last_w) ? min_last_w : fin_raw;
    assign col_emit   = !y_hi[POS_W-1] && (first_w <= fin_w);
    assign col_go     = !(col_emit && pend_valid_reg && !out_free);
    assign col_end    = cx_reg == lastc_reg;

    always_comb begin
        col_res              = '0;
        col_res.major_cell   = cx_reg;
        col_res.minor_first  = first_w[CELL_W-1:0];
        col_res.minor_final  = fin_w[CELL_W-1:0];
        col_res.axes_swapped = sw_reg;
        col_res.fault        = FLT_NONE;
    end

    // ---- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_PREP;
            ST_PREP:  state_next = zero_len ? ST_FLUSH : ST_CHECK;
            ST_CHECK: state_next = (end_below || !has_cols) ? ST_FLUSH : ST_DIV;
            ST_DIV:   if (md_rsp.done) state_next = ST_MUL;
            ST_MUL:   if (md_rsp.done) state_next = ST_EDGE;
            ST_EDGE:  state_next = ST_COL;
            ST_COL:   if (col_go && col_end) state_next = ST_FLUSH;
            ST_FLUSH: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---- outputs of the sequencer
    always_comb begin
        s_ready       = 1'b0;
        md_req        = '0;
        md_req.op     = MD_DIV;
        push          = 1'b0;
        push_data     = pend_reg;
        case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_CHECK: begin
                md_req.start  = !end_below && has_cols;
                md_req.op     = MD_DIV;
                md_req.opnd_a = vy_abs[MD_N-1:0];
                md_req.opnd_b = vx_reg[MD_N-1:0];
            end
            ST_DIV: begin
                md_req.start  = md_rsp.done;
                md_req.op     = MD_MUL;
                md_req.opnd_a = {{(MD_N-DIV_STEPS){1'b0}}, quot};
                md_req.opnd_b = rx_abs[MD_N-1:0];
            end
            ST_COL: begin
                push      = col_go && col_emit && pend_valid_reg;
                push_data = pend_reg;
            end
            ST_FLUSH: begin
                push = out_free;
                if (pend_valid_reg) begin
                    push_data      = pend_reg;
                    push_data.last = 1'b1;
                end else begin
                    push_data              = '0;
                    push_data.axes_swapped = sw_reg;
                    push_data.fault        = fault_reg;
                    push_data.empty_res    = 1'b1;
                    push_data.last         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept)
                pend_valid_reg <= 1'b0;
            else if (state_reg == ST_COL && col_go && col_emit)
                pend_valid_reg <= 1'b1;
            else if (state_reg == ST_FLUSH && out_free)
                pend_valid_reg <= 1'b0;
            if (push)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---- datapath registers
    always_ff @(posedge aclk) begin
        if (push)
            out_reg <= push_data;
        case (state_reg)
            ST_IDLE: if (accept) begin
                px_reg <= (POS_W'(s_data.start_x) - POS_W'(cfg.origin_x)) <<< 1;
                py_reg <= (POS_W'(s_data.start_y) - POS_W'(cfg.origin_y)) <<< 1;
                dx_reg <= POS_W'(s_data.dir_x) <<< 1;
                dy_reg <= POS_W'(s_data.dir_y) <<< 1;
                reach_reg <= POS_W'({2'b00, cfg.reach_radius})
                           + POS_W'({1'b0, cfg.reach_radius, 1'b0});
            end
            ST_PREP: begin
                sw_reg    <= zero_len ? 1'b0 : swap;
                fault_reg <= zero_len ? FLT_ZERO : FLT_NONE;
                if (mj_v[POS_W-1]) begin
                    rx_reg <= mj_r + mj_v;
                    ry_reg <= mn_r + mn_v;
                    vx_reg <= -mj_v;
                    vy_reg <= -mn_v;
                end else begin
                    rx_reg <= mj_r;
                    ry_reg <= mn_r;
                    vx_reg <= mj_v;
                    vy_reg <= mn_v;
                end
                maj_last_reg <= $signed({1'b0, swap ? rows_sat : cols_sat}) - 8'sd1;
                min_last_reg <= $signed({1'b0, swap ? cols_sat : rows_sat}) - 8'sd1;
            end
            ST_CHECK: begin
                if (end_below)
                    fault_reg <= FLT_BELOW;
                cx_reg    <= cx_full[CELL_W-1:0];
                lastc_reg <= lastc[CELL_W-1:0];
            end
            ST_DIV: if (md_rsp.done) begin
                slope_reg    <= slope_new;
                prod_neg_reg <= vy_reg[POS_W-1] ^ rx_reg[POS_W-1];
            end
            ST_MUL: if (md_rsp.done) begin
                y0_reg <= ry_reg - prod_sh[POS_W-1:0];
                e_reg  <= POS_W'(e_init);
            end
            ST_EDGE: yedge_reg <= (e_reg >>> EDGE_SH) + y0_reg;
            ST_COL: if (col_go) begin
                e_reg     <= e_n;
                yedge_reg <= y_n;
                cx_reg    <= cx_reg + 1'b1;
                if (col_emit)
                    pend_reg <= col_res;
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending span left over in idle");
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.empty_res) |-> m_data.last)
        else $error("empty result not marked last");
    a_fault_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.fault != FLT_NONE) |-> m_data.empty_res)
        else $error("faulted result carries a span");
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COL) |-> (cx_reg <= lastc_reg))
        else $error("column walk past last column");
    a_md_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> (state_reg == ST_DIV || state_reg == ST_MUL))
        else $error("shared unit finished outside a wait state");
`endif

endmodule
